// File: sv/utf8v_pkg.sv
// ---------------------------------------------------------------------------
// utf8v_pkg
// shared types and constants of the utf-8 text validator
// ---------------------------------------------------------------------------
package utf8v_pkg;

    // string length counter, one bit wider so it saturates above any limit
    localparam int LENGTH_BITS = 24;
    localparam int COUNT_W     = LENGTH_BITS + 1;
    localparam int MAX_W       = 24;
    localparam int CMP_W       = (COUNT_W > MAX_W) ? COUNT_W : MAX_W;
    localparam int ACC_W       = 21;
    localparam int LEN_W       = 3;
    localparam int OWED_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [MAX_W-1:0]   MAX_BYTES_RST = MAX_W'(4096);

    // register map
    localparam logic REG_MAX_BYTES = 1'b0;

    // byte classes
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // code point limits
    localparam logic [ACC_W-1:0] MIN_3BYTE  = ACC_W'(32'h800);
    localparam logic [ACC_W-1:0] MIN_4BYTE  = ACC_W'(32'h10000);
    localparam logic [ACC_W-1:0] SURR_LOW   = ACC_W'(32'hD800);
    localparam logic [ACC_W-1:0] SURR_HIGH  = ACC_W'(32'hDFFF);
    localparam logic [ACC_W-1:0] CODE_LIMIT = ACC_W'(32'h10FFFF);

    localparam logic [LEN_W-1:0] SEQ_LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] SEQ_LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_LEN_4 = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       no_byte;
    } item_t;

    typedef struct packed {
        logic load;
        logic valid_res;
    } result_t;

endpackage

// File: sv/utf8_text_validator_unit.sv
// ---------------------------------------------------------------------------
// utf8_text_validator_unit
// streaming utf-8 text checker with one pass/fail result per string
// ---------------------------------------------------------------------------
// A string enters one byte per item on the slave side; tlast marks its final
// item and tuser set means that item carries no byte and only closes the
// string. Each byte goes through an input register, combinational checks
// against the running per-string state, and, on the final item, into a result
// register, so one item is taken per clock cycle unless a final item waits,
// and the verdict is loaded as the final item leaves the input register. A
// string passes when it is non-empty, no longer than max_bytes, leaves no
// multi-byte sequence open and holds only legal utf-8 with no control
// characters other than tab and newline and no DEL. Only the result register
// can hold the stream back: a final item waits while an earlier verdict is
// still untaken. max_bytes sits at APB byte address 0 (bits 23:0, reset 4096);
// the user must write it only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module utf8_text_validator_unit
    import utf8v_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last
    input  logic        s_tuser,    // [0] no_byte
    // master side item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] valid_res, [7:1] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             item_vld;
    item_t            item;
    logic             advance;
    logic             res_free;
    result_t          result;
    logic [MAX_W-1:0] max_bytes_reg;
    logic             cfg_wr;

    // register file: one 24-bit limit, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else if (cfg_wr)
        begin
            max_bytes_reg <= pwdata[MAX_W-1:0];
        end
    end

    // unmapped words read as zero
    assign prdata = (paddr[2] == REG_MAX_BYTES) ? {{(32-MAX_W){1'b0}}, max_bytes_reg} : '0;

    utf8v_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    // state update and byte checks, one item per cycle unless a final item waits
    utf8v_check_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_vld  (item_vld),
        .item      (item),
        .res_free  (res_free),
        .max_bytes (max_bytes_reg),
        .advance   (advance),
        .result    (result)
    );

    utf8v_result_stage u_result
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/utf8v_input_stage.sv
// ---------------------------------------------------------------------------
// utf8v_input_stage
// input register, refilled in the same cycle it drains
// ---------------------------------------------------------------------------
module utf8v_input_stage
    import utf8v_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       s_tuser,
    input  logic       advance,
    output logic       item_vld,
    output item_t      item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_tready = !vld_reg || advance;
    assign vld_next = s_tready ? s_tvalid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= '{data_byte: s_tdata, last: s_tlast, no_byte: s_tuser};
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// File: sv/utf8v_check_core.sv
// ---------------------------------------------------------------------------
// utf8v_check_core
// per-string running state and the byte checks of one item
// ---------------------------------------------------------------------------
module utf8v_check_core
    import utf8v_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_vld,
    input  item_t            item,
    input  logic             res_free,
    input  logic [MAX_W-1:0] max_bytes,
    output logic             advance,
    output result_t          result
);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [OWED_W-1:0]  bytes_owed_reg, bytes_owed_next;
    logic [LEN_W-1:0]   seq_len_reg, seq_len_next;
    logic [ACC_W-1:0]   code_acc_reg, code_acc_next;
    logic               failed_reg, failed_next;
    logic [ACC_W-1:0]   acc_shift;
    logic [7:0]         b;
    logic               seq_bad;
    logic               ok;

    assign b         = item.data_byte;
    assign acc_shift = {code_acc_reg[ACC_W-7:0], b[5:0]};

    // overlong, surrogate and out-of-range checks on the finished code point
    always_comb
    begin
        seq_bad = 1'b0;
        if (seq_len_reg == SEQ_LEN_3 && acc_shift < MIN_3BYTE)
        begin
            seq_bad = 1'b1;
        end
        if (seq_len_reg == SEQ_LEN_4 && acc_shift < MIN_4BYTE)
        begin
            seq_bad = 1'b1;
        end
        if (acc_shift >= SURR_LOW && acc_shift <= SURR_HIGH)
        begin
            seq_bad = 1'b1;
        end
        if (acc_shift > CODE_LIMIT)
        begin
            seq_bad = 1'b1;
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        bytes_owed_next = bytes_owed_reg;
        seq_len_next    = seq_len_reg;
        code_acc_next   = code_acc_reg;
        failed_next     = failed_reg;
        if (!item.no_byte)
        begin
            if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
            if (!failed_reg)
            begin
                if (bytes_owed_reg == '0)
                begin
                    priority if ((b < CTRL_LIMIT && b != CHAR_LF && b != CHAR_TAB)
                                 || b == CHAR_DEL)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (!b[7])
                    begin
                        seq_len_next  = SEQ_LEN_1;
                        code_acc_next = {{(ACC_W-8){1'b0}}, b};
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        if (b[4:1] == 4'd0)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            seq_len_next    = SEQ_LEN_2;
                            code_acc_next   = {{(ACC_W-5){1'b0}}, b[4:0]};
                            bytes_owed_next = 2'd1;
                        end
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        seq_len_next    = SEQ_LEN_3;
                        code_acc_next   = {{(ACC_W-4){1'b0}}, b[3:0]};
                        bytes_owed_next = 2'd2;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        seq_len_next    = SEQ_LEN_4;
                        code_acc_next   = {{(ACC_W-3){1'b0}}, b[2:0]};
                        bytes_owed_next = 2'd3;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    code_acc_next   = acc_shift;
                    bytes_owed_next = bytes_owed_reg - 1'b1;
                    if (bytes_owed_reg == 2'd1 && seq_bad)
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    assign ok = !failed_next && bytes_owed_next == '0 && byte_count_next != '0 &&
                CMP_W'(byte_count_next) <= CMP_W'(max_bytes);

    // a non-last item never waits on the result register
    assign advance          = item_vld && (!item.last || res_free);
    assign result.load      = advance && item.last;
    assign result.valid_res = ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            bytes_owed_reg <= '0;
            seq_len_reg    <= '0;
            code_acc_reg   <= '0;
            failed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                byte_count_reg <= '0;
                bytes_owed_reg <= '0;
                seq_len_reg    <= '0;
                code_acc_reg   <= '0;
                failed_reg     <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                bytes_owed_reg <= bytes_owed_next;
                seq_len_reg    <= seq_len_next;
                code_acc_reg   <= code_acc_next;
                failed_reg     <= failed_next;
            end
        end
    end

endmodule

// File: sv/utf8v_result_stage.sv
// ---------------------------------------------------------------------------
// utf8v_result_stage
// result register toward the master side
// ---------------------------------------------------------------------------
module utf8v_result_stage
    import utf8v_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    result,
    output logic       res_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic vld_reg, vld_next;
    logic res_reg;

    assign res_free = !vld_reg || m_tready;

    always_comb
    begin
        vld_next = vld_reg;
        if (result.load)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            res_reg <= result.valid_res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {7'd0, res_reg};

endmodule

// File: sv/utf8v_checker.sv
// ---------------------------------------------------------------------------
// utf8v_checker
// port-level checks of the validator, bound to the top level
// ---------------------------------------------------------------------------
module utf8v_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled verdict holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // a new verdict follows an accepted final item
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("verdict without a final item");

    // only bit 0 of the verdict carries data
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("verdict padding not zero");

    // the limit reads back what was written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
        |-> prdata == {8'd0, $past(pwdata[23:0])})
        else $error("limit readback mismatch");

endmodule

bind utf8_text_validator_unit utf8v_checker u_checker (.*);
